[rtl/gffra_pkg.sv]
package gffra_pkg;

   localparam int DEF_GRID_ROWS = 8;
   localparam int DEF_GRID_COLS = 16;

   localparam int TYPE_W = 2;
   localparam int OCOL_W = 4;
   localparam int OROW_W = 3;
   localparam int WID_W  = 5;
   localparam int HGT_W  = 4;

   localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_PLACE = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd2;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

[rtl/gffra_if.sv]
interface gffra_req_if import gffra_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [OCOL_W-1:0] origin_col;
   logic [OROW_W-1:0] origin_row;
   logic [WID_W-1:0]  rect_width;
   logic [HGT_W-1:0]  rect_height;

   modport source (output valid, req_type, origin_col, origin_row, rect_width, rect_height,
                   input ready);
   modport sink (input valid, req_type, origin_col, origin_row, rect_width, rect_height,
                 output ready);
endinterface

interface gffra_rsp_if import gffra_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              success;
   logic [OCOL_W-1:0] placed_col;
   logic [OROW_W-1:0] placed_row;

   modport source (output valid, success, placed_col, placed_row, input ready);
   modport sink (input valid, success, placed_col, placed_row, output ready);
endinterface

[rtl/gffra_occ_mem.sv]
module gffra_occ_mem import gffra_pkg::*; #(
   parameter int GRID_ROWS = DEF_GRID_ROWS,
   parameter int GRID_COLS = DEF_GRID_COLS,
   parameter int RW        = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mem_ctl_type          ctl,
   input  logic [RW-1:0]        rd_addr,
   input  logic [RW-1:0]        wr_addr,
   input  logic [GRID_COLS-1:0] wr_data,
   output logic [GRID_COLS-1:0] rd_data
);

   logic [GRID_COLS-1:0] mem_ff [GRID_ROWS];
   logic [GRID_ROWS-1:0] row_valid_ff;
   logic [GRID_COLS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (ctl.wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // a row never written since reset reads as all free
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= row_valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

`ifndef SYNTHESIS
   a_no_rd_wr_same_row: assert property (@(posedge clock) disable iff (reset)
      ctl.rd_en && ctl.wr_en |-> rd_addr != wr_addr)
      else $error("read and write hit the same row");
   a_rd_in_grid: assert property (@(posedge clock) disable iff (reset)
      ctl.rd_en |-> 32'(rd_addr) < GRID_ROWS)
      else $error("read row outside grid");
   a_wr_in_grid: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |-> 32'(wr_addr) < GRID_ROWS)
      else $error("write row outside grid");
   a_reset_clears: assert property (@(posedge clock)
      reset |=> row_valid_ff == '0)
      else $error("row valid bits not cleared by reset");
`endif

endmodule

[rtl/grid_first_fit_region_allocator_core.sv]
// Allocate: each tried origin row first ORs together the h rows under the window, then makes
// up to GRID_COLS-w+1 column checks (one window compare per cycle); a fit then reads and
// writes back the h rows to mark the cells.
// Throughput: one request at a time; ready is high only while the sequencer idles,
// the row memory's single read and single write port set the per-row cost.
// Reset (synchronous): clears the row valid bits so the whole grid reads free at once.
module grid_first_fit_region_allocator_core import gffra_pkg::*; #(
   parameter int GRID_ROWS = DEF_GRID_ROWS,
   parameter int GRID_COLS = DEF_GRID_COLS
) (
   input logic         clock,
   input logic         reset,
   gffra_req_if.sink   req_chan,
   gffra_rsp_if.source rsp_chan
);

   localparam int RW  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int RCW = $clog2(GRID_ROWS + 16) + 1;
   localparam int CCW = $clog2(GRID_COLS + 32) + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ACC  = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_MARK = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [TYPE_W-1:0]    type_ff, type_in;
   logic [WID_W-1:0]     w_ff, w_in;
   logic [HGT_W-1:0]     h_ff, h_in;
   logic [RCW-1:0]       base_ff, base_in;
   logic [CCW-1:0]       col_ff, col_in;
   logic [GRID_COLS-1:0] acc_ff, acc_in;
   logic [HGT_W-1:0]     cnt_ff, cnt_in;
   logic [HGT_W-1:0]     nrows_ff, nrows_in;
   logic                 pend_ff, pend_in;
   logic [RW-1:0]        pend_row_ff, pend_row_in;
   logic                 clear_ff, clear_in;
   logic                 ok_ff, ok_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [OCOL_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [OROW_W-1:0]    rsp_row_ff, rsp_row_in;

   mem_ctl_type          mem_ctl;
   logic [RW-1:0]        row_addr;
   logic [GRID_COLS-1:0] rd_data;
   logic [GRID_COLS-1:0] wr_data;
   logic [GRID_COLS-1:0] span_mask;
   logic [CCW-1:0]       col_end;
   logic                 col_fits;
   logic                 window_free;
   logic                 issue;
   logic                 load;
   logic                 accept;
   logic [RCW-1:0]       base_next;
   logic [RCW-1:0]       in_row;
   logic [RCW-1:0]       in_row_end;
   logic [RCW-1:0]       in_room;
   logic [CCW-1:0]       in_col;
   logic [CCW-1:0]       in_col_end;
   logic                 in_origin_ok;

   // shared window compare: span of w cells at the current column against the row window
   assign col_end  = col_ff + CCW'(w_ff);
   assign col_fits = col_end <= CCW'(GRID_COLS);

   always_comb begin
      for (int i = 0; i < GRID_COLS; i++) begin
         span_mask[i] = (CCW'(i) >= col_ff) && (CCW'(i) < col_end);
      end
   end

   assign window_free = (acc_ff & span_mask) == '0;
   assign issue       = cnt_ff < nrows_ff;
   assign row_addr    = RW'(base_ff + RCW'(cnt_ff));
   assign base_next   = base_ff + RCW'(1);
   assign wr_data     = clear_ff ? (rd_data & ~span_mask) : (rd_data | span_mask);

   assign in_row       = RCW'(req_chan.origin_row);
   assign in_row_end   = in_row + RCW'(req_chan.rect_height);
   assign in_room      = RCW'(GRID_ROWS) - in_row;
   assign in_col       = CCW'(req_chan.origin_col);
   assign in_col_end   = in_col + CCW'(req_chan.rect_width);
   assign in_origin_ok = (in_row < RCW'(GRID_ROWS)) && (in_col < CCW'(GRID_COLS));

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign load           = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      base_in       = base_ff;
      col_in        = col_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      nrows_in      = nrows_ff;
      pend_in       = 1'b0;
      pend_row_in   = row_addr;
      clear_in      = clear_ff;
      ok_in         = ok_ff;
      mem_ctl.rd_en = 1'b0;
      mem_ctl.wr_en = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               type_in  = req_chan.req_type;
               w_in     = req_chan.rect_width;
               h_in     = req_chan.rect_height;
               base_in  = in_row;
               col_in   = in_col;
               acc_in   = '0;
               cnt_in   = '0;
               nrows_in = req_chan.rect_height;
               clear_in = 1'b0;
               ok_in    = 1'b0;
               state_in = ST_DONE;
               if (req_chan.rect_width != '0 && req_chan.rect_height != '0) begin
                  unique case (req_chan.req_type)
                     REQ_ALLOC: begin
                        base_in = '0;
                        col_in  = '0;
                        if (RCW'(req_chan.rect_height) <= RCW'(GRID_ROWS)) begin
                           state_in = ST_ACC;
                        end
                     end
                     REQ_PLACE: begin
                        if (in_origin_ok && in_col_end <= CCW'(GRID_COLS) &&
                            in_row_end <= RCW'(GRID_ROWS)) begin
                           state_in = ST_ACC;
                        end
                     end
                     REQ_FREE: begin
                        ok_in = 1'b1;
                        if (in_origin_ok) begin
                           // clip the row count to the grid
                           clear_in = 1'b1;
                           nrows_in = (RCW'(req_chan.rect_height) > in_room) ?
                                      HGT_W'(in_room) : req_chan.rect_height;
                           state_in = ST_MARK;
                        end
                     end
                     default: begin
                        state_in = ST_DONE;
                     end
                  endcase
               end
            end
         end
         ST_ACC: begin
            // OR the rows under the window, one read a cycle
            mem_ctl.rd_en = issue;
            pend_in       = issue;
            if (issue) begin
               cnt_in = cnt_ff + HGT_W'(1);
            end
            if (pend_ff) begin
               acc_in = acc_ff | rd_data;
            end
            if (!issue && !pend_ff) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (col_fits && window_free) begin
               cnt_in   = '0;
               ok_in    = 1'b1;
               state_in = ST_MARK;
            end else if (type_ff == REQ_PLACE) begin
               state_in = ST_DONE;
            end else if (col_fits && col_end != CCW'(GRID_COLS)) begin
               col_in = col_ff + CCW'(1);
            end else if (base_next + RCW'(h_ff) > RCW'(GRID_ROWS)) begin
               state_in = ST_DONE;
            end else begin
               // advance to the next origin row
               base_in  = base_next;
               col_in   = '0;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_ACC;
            end
         end
         ST_MARK: begin
            // read a row, write it back marked or cleared on the following cycle
            mem_ctl.rd_en = issue;
            pend_in       = issue;
            mem_ctl.wr_en = pend_ff;
            if (issue) begin
               cnt_in = cnt_ff + HGT_W'(1);
            end
            if (!issue && !pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = ok_ff;
         rsp_col_in   = ok_ff ? col_ff[OCOL_W-1:0] : '0;
         rsp_row_in   = ok_ff ? base_ff[OROW_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      base_ff     <= base_in;
      col_ff      <= col_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      nrows_ff    <= nrows_in;
      pend_row_ff <= pend_row_in;
      clear_ff    <= clear_in;
      ok_ff       <= ok_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.success    = rsp_ok_ff;
   assign rsp_chan.placed_col = rsp_col_ff;
   assign rsp_chan.placed_row = rsp_row_ff;

   gffra_occ_mem #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS),
      .RW        (RW)
   ) u_occ_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_addr (row_addr),
      .wr_addr (pend_row_ff),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("request accepted but sequencer stayed idle");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC || state_ff == ST_MARK) |-> cnt_ff <= nrows_ff)
      else $error("row counter ran past row count");
   a_mark_in_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK && !clear_ff) |->
         (col_fits && base_ff + RCW'(h_ff) <= RCW'(GRID_ROWS)))
      else $error("marking a region outside the grid");
   a_scan_needs_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !pend_ff)
      else $error("window compare with a row read still in flight");
`endif

endmodule
